/* hdl/cde_pkg.sv */
package cde_pkg;

   // Command codes carried on the request channel.
   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_REPORT     = 3'd4
   } cde_cmd_type;

   // Status codes returned with every response.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } cde_status_type;

   // What one chain does in one cycle. UP moves every word one cell toward the
   // high end, DOWN one cell toward the low end, LOAD writes the pushed word
   // into the single cell whose index matches the load position.
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_UP   = 2'd1,
      CELL_DOWN = 2'd2,
      CELL_LOAD = 2'd3
   } cde_cell_op_type;

   typedef struct packed {
      cde_cell_op_type a_op;
      cde_cell_op_type b_op;
   } cde_cell_ctrl_type;

   typedef struct packed {
      cde_status_type     status;
      logic signed [31:0] removed_value;
      logic signed [31:0] front_value;
      logic signed [31:0] rear_value;
      logic [4:0]         item_count;
      logic               is_empty;
      logic               is_full;
   } cde_result_type;

endpackage

/* hdl/cde_cell.sv */
module cde_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  cde_pkg::cde_cell_ctrl_type     ctrl,
   input  logic [$clog2(DEPTH)-1:0]       a_pos,
   input  logic [$clog2(DEPTH)-1:0]       b_pos,
   input  logic signed [31:0]             push_word,
   input  logic signed [31:0]             a_lower_word,
   input  logic signed [31:0]             a_upper_word,
   input  logic signed [31:0]             b_lower_word,
   input  logic signed [31:0]             b_upper_word,
   output logic signed [31:0]             a_word,
   output logic signed [31:0]             b_word
);

   localparam int IDX_W = $clog2(DEPTH);

   logic signed [31:0] a_word_ff;
   logic signed [31:0] a_word_in;
   logic signed [31:0] b_word_ff;
   logic signed [31:0] b_word_in;

   // Both chains follow the same rule; only the load position differs.
   always_comb begin
      a_word_in = a_word_ff;
      case (ctrl.a_op)
         cde_pkg::CELL_UP:   a_word_in = a_lower_word;
         cde_pkg::CELL_DOWN: a_word_in = a_upper_word;
         cde_pkg::CELL_LOAD: begin
            if (a_pos == IDX_W'(INDEX)) begin
               a_word_in = push_word;
            end
         end
         default: a_word_in = a_word_ff;
      endcase
   end

   always_comb begin
      b_word_in = b_word_ff;
      case (ctrl.b_op)
         cde_pkg::CELL_UP:   b_word_in = b_lower_word;
         cde_pkg::CELL_DOWN: b_word_in = b_upper_word;
         cde_pkg::CELL_LOAD: begin
            if (b_pos == IDX_W'(INDEX)) begin
               b_word_in = push_word;
            end
         end
         default: b_word_in = b_word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      a_word_ff <= a_word_in;
      b_word_ff <= b_word_in;
   end

   assign a_word = a_word_ff;
   assign b_word = b_word_ff;

endmodule

/* hdl/circular_deque_engine_top.sv */
// Double-ended queue of up to DEPTH signed 32-bit words.
//
// Requests arrive on req_valid / req_stall with a command (push front, push
// rear, pop front, pop rear, report) and a word to push. Every request yields
// exactly one response on rsp_valid / rsp_stall carrying the status, the word
// removed by a pop, the front and rear words, the count and the empty and full
// flags, all as they stand after the request.
//
// A response is registered in the output register when its request is
// accepted, or in the skid register while the output waits. One request is
// taken per cycle, limited only by this two-entry response buffer. While the
// receiver stalls, one more request is still accepted and parked in the skid
// register, after which req_stall rises until the receiver drains the output.
//
// Reset empties the queue at once (count zero) and drops any pending
// responses. The stored words themselves are not cleared; an empty queue
// reports zero for its front and rear words. There is no clearing pass, so
// requests are taken as soon as reset is released.
module circular_deque_engine_top #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic signed [31:0] rsp_front_value,
   output logic signed [31:0] rsp_rear_value,
   output logic [4:0]         rsp_item_count,
   output logic               rsp_is_empty,
   output logic               rsp_is_full
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // The words are held twice, in two chains of cells. Chain A keeps the
   // front word in cell 0 and the rest in order behind it. Chain B keeps the
   // rear word in cell DEPTH-1 and the rest in order before it. Every end of
   // the queue that a request touches therefore sits at a fixed cell, and a
   // push at the far end of a chain is a load into the cell at the count
   // (chain A) or at DEPTH-1 minus the count (chain B).
   logic signed [31:0] a_word [DEPTH];
   logic signed [31:0] b_word [DEPTH];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   cde_pkg::cde_cell_ctrl_type cell_ctrl;
   cde_pkg::cde_result_type    result;

   logic [IDX_W-1:0] a_pos;
   logic [IDX_W-1:0] b_pos;

   logic req_accept;
   logic rsp_take;
   logic is_full_now;
   logic is_empty_now;

   // Response buffer: an output register plus one skid register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   cde_pkg::cde_result_type rsp_data_ff;
   cde_pkg::cde_result_type rsp_data_in;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   cde_pkg::cde_result_type skid_data_ff;
   cde_pkg::cde_result_type skid_data_in;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   assign is_full_now  = (count_ff == CNT_W'(DEPTH));
   assign is_empty_now = (count_ff == '0);

   // Load positions; they are only used when the queue is not full, so the
   // count then fits the index width.
   assign a_pos = count_ff[IDX_W-1:0];
   assign b_pos = IDX_W'(DEPTH - 1) - count_ff[IDX_W-1:0];

   // Decode the request into chain operations, the next count and the
   // response fields. Unknown command codes behave as a report.
   always_comb begin
      cell_ctrl.a_op       = cde_pkg::CELL_HOLD;
      cell_ctrl.b_op       = cde_pkg::CELL_HOLD;
      count_in             = count_ff;
      result.status        = cde_pkg::ST_OK;
      result.removed_value = '0;
      result.front_value   = a_word[0];
      result.rear_value    = b_word[DEPTH-1];
      case (req_cmd)
         cde_pkg::CMD_PUSH_FRONT: begin
            if (is_full_now) begin
               result.status = cde_pkg::ST_OVERFLOW;
            end else begin
               cell_ctrl.a_op     = cde_pkg::CELL_UP;
               cell_ctrl.b_op     = cde_pkg::CELL_LOAD;
               count_in           = count_ff + 1'b1;
               result.front_value = req_value;
               if (is_empty_now) begin
                  result.rear_value = req_value;
               end
            end
         end
         cde_pkg::CMD_PUSH_REAR: begin
            if (is_full_now) begin
               result.status = cde_pkg::ST_OVERFLOW;
            end else begin
               cell_ctrl.a_op    = cde_pkg::CELL_LOAD;
               cell_ctrl.b_op    = cde_pkg::CELL_DOWN;
               count_in          = count_ff + 1'b1;
               result.rear_value = req_value;
               if (is_empty_now) begin
                  result.front_value = req_value;
               end
            end
         end
         cde_pkg::CMD_POP_FRONT: begin
            if (is_empty_now) begin
               result.status = cde_pkg::ST_UNDERFLOW;
            end else begin
               cell_ctrl.a_op       = cde_pkg::CELL_DOWN;
               count_in             = count_ff - 1'b1;
               result.removed_value = a_word[0];
               result.front_value   = a_word[1];
            end
         end
         cde_pkg::CMD_POP_REAR: begin
            if (is_empty_now) begin
               result.status = cde_pkg::ST_UNDERFLOW;
            end else begin
               cell_ctrl.b_op       = cde_pkg::CELL_UP;
               count_in             = count_ff - 1'b1;
               result.removed_value = b_word[DEPTH-1];
               result.rear_value    = b_word[DEPTH-2];
            end
         end
         default: begin
            cell_ctrl.a_op = cde_pkg::CELL_HOLD;
            cell_ctrl.b_op = cde_pkg::CELL_HOLD;
         end
      endcase

      if (!req_accept) begin
         cell_ctrl.a_op = cde_pkg::CELL_HOLD;
         cell_ctrl.b_op = cde_pkg::CELL_HOLD;
         count_in       = count_ff;
      end

      result.is_empty   = (count_in == '0);
      result.is_full    = (count_in == CNT_W'(DEPTH));
      result.item_count = 5'(count_in);
      if (result.is_empty) begin
         result.front_value = '0;
         result.rear_value  = '0;
      end
   end

   // The row of cells. The open ends of both chains take the pushed word; the
   // ends that would shift in from outside are never read afterwards.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] a_lower;
      logic signed [31:0] a_upper;
      logic signed [31:0] b_lower;
      logic signed [31:0] b_upper;

      if (i == 0) begin : g_low_end
         assign a_lower = req_value;
         assign b_lower = req_value;
      end else begin : g_low_mid
         assign a_lower = a_word[i-1];
         assign b_lower = b_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_high_end
         assign a_upper = req_value;
         assign b_upper = req_value;
      end else begin : g_high_mid
         assign a_upper = a_word[i+1];
         assign b_upper = b_word[i+1];
      end

      cde_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl),
         .a_pos        (a_pos),
         .b_pos        (b_pos),
         .push_word    (req_value),
         .a_lower_word (a_lower),
         .a_upper_word (a_upper),
         .b_lower_word (b_lower),
         .b_upper_word (b_upper),
         .a_word       (a_word[i]),
         .b_word       (b_word[i])
      );
   end

   // Response buffer. A new response goes to the output register when it is
   // empty or being drained, otherwise into the skid register. Requests are
   // held off only while the skid register is occupied.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = req_accept;
            rsp_data_in  = result;
         end
      end else if (req_accept) begin
         if (rsp_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_removed_value = rsp_data_ff.removed_value;
   assign rsp_front_value   = rsp_data_ff.front_value;
   assign rsp_rear_value    = rsp_data_ff.rear_value;
   assign rsp_item_count    = rsp_data_ff.item_count;
   assign rsp_is_empty      = rsp_data_ff.is_empty;
   assign rsp_is_full       = rsp_data_ff.is_full;

   // The count never goes past the capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count exceeds capacity");

   // The skid register is only filled behind a waiting output register.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // A push into a queue with room grows it by exactly one word.
   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_full_now &&
       (req_cmd == cde_pkg::CMD_PUSH_FRONT || req_cmd == cde_pkg::CMD_PUSH_REAR))
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the queue by one");

   // An overflow is only reported by a full queue.
   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status == cde_pkg::ST_OVERFLOW) |-> rsp_is_full)
      else $error("overflow reported on a queue that is not full");

   // An underflow is only reported by an empty queue.
   a_underflow_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status == cde_pkg::ST_UNDERFLOW) |-> rsp_is_empty)
      else $error("underflow reported on a queue that is not empty");

endmodule
